@@ hdl/sqts_pkg.sv @@
// ----------------------------------------------------------------------------
// sqts_pkg
// Shared types, constants and helpers for the SARSA Q table step block.
// ----------------------------------------------------------------------------
package sqts_pkg;

  localparam int NUM_STATES = 6;
  localparam int NUM_ACTS   = 3;
  localparam int STATE_W    = 6;
  localparam int ACT_W      = 2;
  localparam int Q_W        = 16;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int DRAW_W     = 8;
  localparam int ROW_W      = NUM_ACTS * Q_W;
  localparam int ROW_AW     = $clog2(NUM_STATES);

  // products and intermediate sums
  localparam int PROD1_W = CFG_W + 1 + Q_W;   // discount * Q(s',a')
  localparam int G_W     = PROD1_W - 8;
  localparam int DIFF_W  = 19;                // r + g - Q(s,a)
  localparam int PROD2_W = CFG_W + 1 + DIFF_W;
  localparam int U_W     = PROD2_W - 8;
  localparam int NV_W    = U_W + 1;

  localparam logic [CFG_W-1:0] LEARN_RATE_RST  = CFG_W'(205);
  localparam logic [CFG_W-1:0] DISCOUNT_RST    = CFG_W'(256);
  localparam logic [CFG_W-1:0] EXPLORE_THR_RST = CFG_W'(26);

  localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 16'sh8000;

  typedef enum logic [ACT_W-1:0] {
    ACT_LEFT  = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_RIGHT = 2'd2
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE  = 2'd0,
    CFG_DISCOUNT    = 2'd1,
    CFG_EXPLORE_THR = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEXT,
    ST_OLD,
    ST_DIFF,
    ST_SCALE,
    ST_WB
  } step_state_e;

  typedef struct packed {
    act_e chosen;
    logic explored;
  } policy_t;

  function automatic logic state_ok(input logic [STATE_W-1:0] st);
    return {1'b0, st} < (STATE_W + 1)'(NUM_STATES);
  endfunction

  function automatic logic act_ok(input logic [ACT_W-1:0] act);
    return act == ACT_LEFT || act == ACT_STOP || act == ACT_RIGHT;
  endfunction

  function automatic logic signed [Q_W-1:0] row_slot(input logic [ROW_W-1:0] row,
                                                     input act_e act);
    return row[act*Q_W +: Q_W];
  endfunction

endpackage

@@ hdl/sqts_ram.sv @@
// ----------------------------------------------------------------------------
// sqts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sqts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/sqts_policy.sv @@
// ----------------------------------------------------------------------------
// sqts_policy
// Epsilon-greedy choice of the next action from one row of the Q table.
// ----------------------------------------------------------------------------
module sqts_policy import sqts_pkg::*; (
  input  logic [ROW_W-1:0]  row_i,
  input  logic [CFG_W-1:0]  explore_thr_i,
  input  logic [DRAW_W-1:0] explore_draw_i,
  input  logic              pick_draw_i,
  output policy_t           policy_o
);

  logic signed [Q_W-1:0] q_left, q_stop, q_right;
  act_e greedy, slot0, slot1;
  logic explore;

  assign q_left  = row_slot(row_i, ACT_LEFT);
  assign q_stop  = row_slot(row_i, ACT_STOP);
  assign q_right = row_slot(row_i, ACT_RIGHT);

  always_comb begin
    priority if (q_left > q_stop && q_left > q_right) begin
      greedy = ACT_LEFT;
    end else if (q_right > q_stop) begin
      greedy = ACT_RIGHT;
    end else begin
      greedy = ACT_STOP;
    end
  end

  // non-greedy slots; greedy STOP fills both with LEFT/RIGHT
  always_comb begin
    unique case (greedy)
      ACT_LEFT: begin
        slot0 = ACT_RIGHT;
        slot1 = ACT_STOP;
      end
      ACT_RIGHT: begin
        slot0 = ACT_LEFT;
        slot1 = ACT_STOP;
      end
      default: begin
        slot0 = ACT_LEFT;
        slot1 = ACT_RIGHT;
      end
    endcase
  end

  assign explore = {1'b0, explore_draw_i} < explore_thr_i;

  always_comb begin
    policy_o.explored = explore;
    if (explore) begin
      policy_o.chosen = pick_draw_i ? slot1 : slot0;
    end else begin
      policy_o.chosen = greedy;
    end
  end

endmodule

@@ hdl/sarsa_q_table_step.sv @@
// ----------------------------------------------------------------------------
// sarsa_q_table_step
// Tabular SARSA step: epsilon-greedy next action and saturating Q update.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The Q table sits in a row memory (one row of
// three Q8.8 values per state) with a single read port, so an item is read in
// two passes (row of the next state, then row of the previous state), followed
// by two registered multiplies (discount, then learn rate) and a write back:
// a new item is taken only in idle, after the previous one's write back,
// and its result is registered at that write back. A finished result waits
// in an output register, so a stalled output does not hold up the following
// beat's processing until its write back. Rows read as zero until written;
// per-row valid flops cleared by reset stand in for a clearing pass, so the
// block is ready right after reset.
// ----------------------------------------------------------------------------
module sarsa_q_table_step import sqts_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [STATE_W-1:0]       prev_state_i,
  input  logic [ACT_W-1:0]         prev_action_i,
  input  logic signed [Q_W-1:0]    reward_i,
  input  logic [STATE_W-1:0]       next_state_i,
  input  logic [DRAW_W-1:0]        explore_draw_i,
  input  logic                     pick_draw_i,
  input  logic                     do_update_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ACT_W-1:0]         chosen_action_o,
  output logic                     explored_o,
  output logic signed [Q_W-1:0]    new_value_o,
  output logic                     saturated_o
);

  // configuration registers
  logic [CFG_W-1:0] learn_rate_q, discount_q, explore_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q  <= LEARN_RATE_RST;
      discount_q    <= DISCOUNT_RST;
      explore_thr_q <= EXPLORE_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LEARN_RATE:  learn_rate_q  <= cfg_data_i;
        CFG_DISCOUNT:    discount_q    <= cfg_data_i;
        CFG_EXPLORE_THR: explore_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  step_state_e state_q, state_d;
  logic        in_fire, out_free, wb_go;
  logic        out_valid_q;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign wb_go    = (state_q == ST_WB) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_NEXT;
      ST_NEXT:  state_d = ST_OLD;
      ST_OLD:   state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_WB;
      ST_WB:    if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // latched beat
  logic [STATE_W-1:0]    ps_q, ns_q;
  logic [ACT_W-1:0]      pa_q;
  logic signed [Q_W-1:0] reward_q;
  logic [DRAW_W-1:0]     draw_q;
  logic                  pick_q, upd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ps_q     <= prev_state_i;
      pa_q     <= prev_action_i;
      reward_q <= reward_i;
      ns_q     <= next_state_i;
      draw_q   <= explore_draw_i;
      pick_q   <= pick_draw_i;
      upd_q    <= do_update_i;
    end
  end

  // row memory and row valid flops
  logic                  ram_we;
  logic [ROW_AW-1:0]     ram_raddr, ram_waddr;
  logic [ROW_W-1:0]      ram_wdata, ram_rdata;
  logic [NUM_STATES-1:0] row_vld_q;
  logic                  wr_ok;

  always_comb begin
    unique case (state_q)
      ST_IDLE: ram_raddr = next_state_i[ROW_AW-1:0];
      default: ram_raddr = ps_q[ROW_AW-1:0];
    endcase
  end

  assign wr_ok     = upd_q && act_ok(pa_q) && state_ok(ps_q);
  assign ram_we    = wb_go && wr_ok;
  assign ram_waddr = ps_q[ROW_AW-1:0];

  sqts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_STATES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (ram_we) begin
      row_vld_q[ram_waddr] <= 1'b1;
    end
  end

  // masked rows: out-of-range or never written reads as zero
  logic [ROW_W-1:0] row_next, row_old;

  assign row_next = (state_ok(ns_q) && row_vld_q[ns_q[ROW_AW-1:0]]) ? ram_rdata : '0;
  assign row_old  = (state_ok(ps_q) && row_vld_q[ps_q[ROW_AW-1:0]]) ? ram_rdata : '0;

  policy_t policy, policy_q;

  sqts_policy u_policy (
    .row_i          (row_next),
    .explore_thr_i  (explore_thr_q),
    .explore_draw_i (draw_q),
    .pick_draw_i    (pick_q),
    .policy_o       (policy)
  );

  // datapath
  logic signed [Q_W-1:0]     qnext_q, qold_q;
  logic [ROW_W-1:0]          row_q;
  logic signed [PROD1_W-1:0] prod1_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PROD2_W-1:0] prod2_q;
  logic signed [G_W-1:0]     g_val;
  logic signed [U_W-1:0]     u_val;
  logic signed [NV_W-1:0]    nv_full;
  logic signed [Q_W-1:0]     nv_clamp;
  logic                      nv_sat;

  // arithmetic shifts give floor division by 256
  assign g_val = G_W'(prod1_q >>> 8);
  assign u_val = U_W'(prod2_q >>> 8);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_NEXT: begin
        policy_q <= policy;
        qnext_q  <= row_slot(row_next, policy.chosen);
      end
      ST_OLD: begin
        row_q   <= row_old;
        qold_q  <= act_ok(pa_q) ? row_slot(row_old, act_e'(pa_q)) : '0;
        prod1_q <= $signed({1'b0, discount_q}) * qnext_q;
      end
      ST_DIFF: begin
        diff_q <= DIFF_W'(reward_q) + DIFF_W'(g_val) - DIFF_W'(qold_q);
      end
      ST_SCALE: begin
        prod2_q <= $signed({1'b0, learn_rate_q}) * diff_q;
      end
      default: ;
    endcase
  end

  assign nv_full = NV_W'(qold_q) + NV_W'(u_val);

  always_comb begin
    priority if (nv_full > NV_W'(Q_MAX)) begin
      nv_clamp = Q_MAX;
      nv_sat   = 1'b1;
    end else if (nv_full < NV_W'(Q_MIN)) begin
      nv_clamp = Q_MIN;
      nv_sat   = 1'b1;
    end else begin
      nv_clamp = Q_W'(nv_full);
      nv_sat   = 1'b0;
    end
  end

  always_comb begin
    ram_wdata = row_q;
    for (int i = 0; i < NUM_ACTS; i++) begin
      if (pa_q == ACT_W'(i)) begin
        ram_wdata[i*Q_W +: Q_W] = nv_clamp;
      end
    end
  end

  // output register
  logic [ACT_W-1:0]      chosen_q;
  logic                  explored_q, sat_q;
  logic signed [Q_W-1:0] new_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      chosen_q    <= policy_q.chosen;
      explored_q  <= policy_q.explored;
      new_value_q <= upd_q ? nv_clamp : qold_q;
      sat_q       <= upd_q && nv_sat;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = chosen_q;
  assign explored_o      = explored_q;
  assign new_value_o     = new_value_q;
  assign saturated_o     = sat_q;

  // checks
  a_we_in_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_WB && state_ok(ps_q))
    else $error("row write outside write back or to an out-of-range state");

  a_wb_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB && out_valid_q && out_stall_i) |=> state_q == ST_WB)
    else $error("write back left while result register blocked");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && sat_q) |-> (new_value_q == Q_MAX || new_value_q == Q_MIN))
    else $error("saturated result not at a bound");

  a_chosen_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> act_ok(chosen_q))
    else $error("illegal chosen action");

  a_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> row_vld_q[$past(ram_waddr)])
    else $error("written row not marked valid");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SARSA Q table step: drives transitions with
// random gaps on both channels and checks each result beat against a local
// Q table predictor.
// ----------------------------------------------------------------------------
module testbench import sqts_pkg::*; ();

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 8;
  localparam int STEPS_PER_PHASE = 222;
  localparam int NUM_PHASES      = 6;
  localparam int SETTLE_CYCLES   = 12;
  localparam int MAX_REPORTS     = 40;
  // covers ~1400 beats, each with the longest source gap and sink stall
  localparam int CYCLE_LIMIT     = 1_000_000;

  typedef struct {
    logic [STATE_W-1:0]    prev_state;
    logic [ACT_W-1:0]      prev_action;
    logic signed [Q_W-1:0] reward;
    logic [STATE_W-1:0]    next_state;
    logic [DRAW_W-1:0]     draw;
    logic                  pick;
    logic                  learn;
  } step_req_t;

  typedef struct {
    logic [ACT_W-1:0]      chosen;
    logic                  explored;
    logic signed [Q_W-1:0] value;
    logic                  saturated;
  } step_res_t;

  class sarsa_scoreboard;
    logic signed [Q_W-1:0] q_tab [NUM_STATES*NUM_ACTS];
    logic [CFG_W-1:0]      alpha, gamma, eps_thr;
    step_res_t             pending[$];
    logic [STATE_W-1:0]    last_next;
    act_e                  last_chosen;
    int errors, n_steps, n_explored, n_clamped, n_noupdate, n_offtable;

    function new();
      foreach (q_tab[i]) q_tab[i] = '0;
      alpha   = LEARN_RATE_RST;
      gamma   = DISCOUNT_RST;
      eps_thr = EXPLORE_THR_RST;
      last_next   = '0;
      last_chosen = ACT_STOP;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LEARN_RATE:  alpha   = val;
        CFG_DISCOUNT:    gamma   = val;
        CFG_EXPLORE_THR: eps_thr = val;
        default: ;
      endcase
    endfunction

    // off-table entries read as zero
    function logic signed [Q_W-1:0] q_at(logic [STATE_W-1:0] st, logic [ACT_W-1:0] act);
      if (st >= NUM_STATES || act >= NUM_ACTS) return '0;
      return q_tab[st*NUM_ACTS + act];
    endfunction

    function void note_step(step_req_t it);
      logic signed [Q_W-1:0] lv, sv, rv;
      act_e                  greedy, chosen;
      step_res_t             want;
      longint                qold, qnext, g, d, nv;
      lv = q_at(it.next_state, ACT_LEFT);
      sv = q_at(it.next_state, ACT_STOP);
      rv = q_at(it.next_state, ACT_RIGHT);
      if (lv > sv && lv > rv) greedy = ACT_LEFT;
      else if (rv > sv) greedy = ACT_RIGHT;
      else greedy = ACT_STOP;
      chosen = greedy;
      want.explored = 1'b0;
      if (it.draw < eps_thr) begin
        want.explored = 1'b1;
        case (greedy)
          ACT_LEFT:  chosen = it.pick ? ACT_STOP : ACT_RIGHT;
          ACT_RIGHT: chosen = it.pick ? ACT_STOP : ACT_LEFT;
          default:   chosen = it.pick ? ACT_RIGHT : ACT_LEFT;
        endcase
      end
      // read of Q(s',a') happens before the write back, also for s == s'
      qold = q_at(it.prev_state, it.prev_action);
      nv = qold;
      want.saturated = 1'b0;
      if (it.learn) begin
        qnext = q_at(it.next_state, chosen);
        g  = (longint'(gamma) * qnext) >>> 8;
        d  = it.reward + g - qold;
        nv = qold + ((longint'(alpha) * d) >>> 8);
        if (nv > 32767) begin
          nv = 32767;
          want.saturated = 1'b1;
        end else if (nv < -32768) begin
          nv = -32768;
          want.saturated = 1'b1;
        end
        if (it.prev_state < NUM_STATES && it.prev_action < NUM_ACTS)
          q_tab[it.prev_state*NUM_ACTS + it.prev_action] = Q_W'(nv);
      end else begin
        n_noupdate++;
      end
      if (it.prev_state >= NUM_STATES || it.prev_action >= NUM_ACTS ||
          it.next_state >= NUM_STATES) n_offtable++;
      want.chosen = chosen;
      want.value  = Q_W'(nv);
      pending.push_back(want);
      n_steps++;
      if (want.explored) n_explored++;
      if (want.saturated) n_clamped++;
      last_next   = it.next_state;
      last_chosen = chosen;
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_result(step_res_t got);
      step_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing outstanding, expected none actual action %0d value %0d",
                   $time, got.chosen, got.value);
        return;
      end
      want = pending.pop_front();
      if (got.chosen !== want.chosen) report("chosen_action", want.chosen, got.chosen);
      if (got.explored !== want.explored) report("explored", want.explored, got.explored);
      if (got.value !== want.value) report("new_value", want.value, got.value);
      if (got.saturated !== want.saturated) report("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [STATE_W-1:0]    prev_state;
  logic [ACT_W-1:0]      prev_action;
  logic signed [Q_W-1:0] reward;
  logic [STATE_W-1:0]    next_state;
  logic [DRAW_W-1:0]     explore_draw;
  logic                  pick_draw;
  logic                  do_update;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ACT_W-1:0]      chosen_action;
  logic                  explored;
  logic signed [Q_W-1:0] new_value;
  logic                  saturated;

  sarsa_scoreboard sb;
  bit  quiet = 1'b0;
  int  sink_hold = 0;
  int  cycles = 0;
  int  n_settings = 1;

  sarsa_q_table_step DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .prev_state_i    (prev_state),
    .prev_action_i   (prev_action),
    .reward_i        (reward),
    .next_state_i    (next_state),
    .explore_draw_i  (explore_draw),
    .pick_draw_i     (pick_draw),
    .do_update_i     (do_update),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .chosen_action_o (chosen_action),
    .explored_o      (explored),
    .new_value_o     (new_value),
    .saturated_o     (saturated)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (sink_hold != 0) begin
      out_stall = 1'b1;
      sink_hold--;
    end else begin
      out_stall = 1'b0;
      if (!quiet && $urandom_range(0, 2) == 0) sink_hold = idle_len();
    end
  end

  always @(posedge clk) begin
    step_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.chosen    = chosen_action;
      got.explored  = explored;
      got.value     = new_value;
      got.saturated = saturated;
      sb.check_result(got);
    end
  end

  function automatic step_req_t mk(int ps, int pa, int r, int ns, int dr, int pk, int ln);
    step_req_t it;
    it.prev_state  = STATE_W'(ps);
    it.prev_action = ACT_W'(pa);
    it.reward      = Q_W'(r);
    it.next_state  = STATE_W'(ns);
    it.draw        = DRAW_W'(dr);
    it.pick        = pk[0];
    it.learn       = ln[0];
    return it;
  endfunction

  function automatic logic [STATE_W-1:0] rand_state();
    if ($urandom_range(0, 99) < 85) return STATE_W'($urandom_range(0, NUM_STATES-1));
    return STATE_W'($urandom_range(0, 63));
  endfunction

  function automatic step_req_t rand_step();
    step_req_t it;
    it.prev_state  = rand_state();
    it.next_state  = rand_state();
    it.prev_action = ($urandom_range(0, 19) == 0) ? ACT_W'(NUM_ACTS)
                                                  : ACT_W'($urandom_range(0, NUM_ACTS-1));
    case ($urandom_range(0, 9))
      0:       it.reward = Q_MAX;
      1:       it.reward = Q_MIN;
      2, 3:    it.reward = Q_W'($urandom);
      default: it.reward = Q_W'($urandom_range(0, 4095) - 2048);
    endcase
    it.draw  = DRAW_W'($urandom_range(0, 255));
    it.pick  = 1'($urandom_range(0, 1));
    it.learn = ($urandom_range(0, 9) != 0);
    // most beats continue the episode: learn on the action just chosen
    if ($urandom_range(0, 9) < 7) begin
      it.prev_state  = sb.last_next;
      it.prev_action = sb.last_chosen;
    end
    return it;
  endfunction

  task automatic send_step(input step_req_t it);
    int gap;
    in_valid     = 1'b1;
    prev_state   = it.prev_state;
    prev_action  = it.prev_action;
    reward       = it.reward;
    next_state   = it.next_state;
    explore_draw = it.draw;
    pick_draw    = it.pick;
    do_update    = it.learn;
    do @(posedge clk); while (in_stall);
    sb.note_step(it);
    @(negedge clk);
    gap = quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_W'(val);
    @(posedge clk);
    sb.write_reg(idx, CFG_W'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_cfg(int a, int g, int t);
    write_reg(CFG_LEARN_RATE, a);
    write_reg(CFG_DISCOUNT, g);
    write_reg(CFG_EXPLORE_THR, t);
    n_settings++;
  endtask

  initial begin
    int a, g, t;
    sb = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_LEARN_RATE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    prev_state   = '0;
    prev_action  = ACT_LEFT;
    reward       = '0;
    next_state   = '0;
    explore_draw = '0;
    pick_draw    = 1'b0;
    do_update    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: alpha 205, gamma 256, threshold 26
    send_step(mk(0, ACT_LEFT, 32767, 0, 255, 0, 1));    // self transition, all zero
    send_step(mk(0, ACT_LEFT, 32767, 0, 255, 0, 1));    // greedy left on itself
    send_step(mk(1, ACT_RIGHT, -32768, 1, 255, 0, 1));
    send_step(mk(2, ACT_RIGHT, 1000, 5, 200, 1, 1));
    send_step(mk(5, ACT_STOP, 0, 0, 0, 0, 1));          // greedy left, explore right
    send_step(mk(5, ACT_STOP, 0, 0, 25, 1, 1));         // explore stop, draw just below
    send_step(mk(5, ACT_LEFT, 256, 0, 26, 1, 1));       // draw at threshold: greedy
    send_step(mk(3, ACT_LEFT, -256, 2, 0, 0, 1));       // greedy right, explore left
    send_step(mk(3, ACT_LEFT, -256, 2, 1, 1, 1));       // greedy right, explore stop
    send_step(mk(4, ACT_RIGHT, 512, 1, 0, 0, 1));       // greedy stop, explore left
    send_step(mk(4, ACT_RIGHT, 512, 1, 3, 1, 1));       // greedy stop, explore right
    send_step(mk(63, ACT_LEFT, 5000, 6, 255, 0, 1));    // both states off the table
    send_step(mk(6, ACT_STOP, -5000, 0, 255, 0, 1));
    send_step(mk(2, NUM_ACTS, 32767, 2, 255, 0, 1));    // invalid action, computed only
    send_step(mk(0, ACT_LEFT, -32768, 0, 255, 0, 0));   // no update
    send_step(mk(2, NUM_ACTS, 0, 0, 255, 1, 0));

    // full step size: drive the table into both clamps
    drain();
    write_cfg(256, 256, 128);
    send_step(mk(3, ACT_LEFT, 32767, 3, 255, 0, 1));
    send_step(mk(3, ACT_LEFT, 32767, 3, 255, 0, 1));
    send_step(mk(1, ACT_RIGHT, -32768, 1, 0, 1, 1));
    send_step(mk(1, ACT_RIGHT, -32768, 1, 0, 1, 1));

    // frozen learning, always exploring
    drain();
    write_cfg(0, 0, 256);
    send_step(mk(0, ACT_STOP, 32767, 3, 255, 1, 1));
    send_step(mk(5, ACT_RIGHT, -32768, 5, 255, 0, 1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          a = int'(LEARN_RATE_RST);
          g = int'(DISCOUNT_RST);
          t = int'(EXPLORE_THR_RST);
        end
        1: begin a = 256; g = 256; t = 0; end
        2: begin a = 0; g = 0; t = 256; end
        3: begin a = 128; g = 230; t = 64; end
        4: begin a = 1; g = 255; t = 255; end
        default: begin
          a = $urandom_range(0, 256);
          g = $urandom_range(0, 256);
          t = $urandom_range(0, 256);
        end
      endcase
      write_cfg(a, g, t);
      for (int n = 0; n < STEPS_PER_PHASE; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_step(rand_step());
        if ($urandom_range(0, 149) == 0) drain();
      end
    end
    quiet = 1'b0;
    drain();

    $display("Covered %0d transitions over %0d register settings: %0d explored, %0d clamped,",
             sb.n_steps, n_settings, sb.n_explored, sb.n_clamped);
    $display("  %0d without update, %0d touching off-table states or actions",
             sb.n_noupdate, sb.n_offtable);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sarsa_q_table_step.f @@
hdl/sqts_pkg.sv
hdl/sqts_ram.sv
hdl/sqts_policy.sv
hdl/sarsa_q_table_step.sv
bench/testbench.sv
